FILE: src/rtds_pkg.sv
// Shared types, constants and a helper function for the radix to digit string unit.
package rtds_pkg;

  localparam int VALUE_WIDTH       = 31;
  localparam int RADIX_WIDTH       = 6;
  localparam int CHAR_WIDTH        = 8;
  localparam int DIGIT_WIDTH       = 6;
  localparam int RADIX_MIN         = 2;
  localparam int DIGIT_LETTER_BASE = 10;
  localparam int DIGIT_MAX         = 35;

  // Bits of quotient developed per division cycle.
  localparam int STEP_BITS  = 8;
  localparam int STEPS      = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int DIV_W      = STEPS * STEP_BITS;
  localparam int STEP_CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic [RADIX_WIDTH-1:0] radix;
  } req_item_t;

  typedef struct packed {
    logic [CHAR_WIDTH-1:0] digit_char;
    logic                  last;
    logic                  no_digits;
    logic                  bad_radix;
  } rsp_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLAG,
    ST_DIV,
    ST_READ,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic start;
    logic div_step;
    logic pop;
    logic load_digit;
    logic load_flag;
  } cmd_t;

  typedef struct packed {
    logic special;
    logic digit_end;
    logic cnt_zero;
    logic out_free;
  } status_t;

  function automatic logic [CHAR_WIDTH-1:0] digit_to_ascii(input logic [DIGIT_WIDTH-1:0] d);
    logic [CHAR_WIDTH-1:0] dx;
    dx = CHAR_WIDTH'(d);
    if (dx < CHAR_WIDTH'(DIGIT_LETTER_BASE)) begin
      digit_to_ascii = 8'h30 + dx;
    end else begin
      digit_to_ascii = 8'h41 + (dx - CHAR_WIDTH'(DIGIT_LETTER_BASE));
    end
  endfunction

endpackage

FILE: src/radix_to_digit_string_unit.sv
// A value is accepted, then each of its digits takes STEPS division steps
// (STEPS = 4 at 31 bits, 8 quotient bits per cycle); the digits are then popped and loaded.
// One item at a time: no new request is taken until the conversion ends, since
// the iterative divider and the single read port of the digit stack are shared.
// A bad radix or a zero value gives one flagged transfer.
// Reset: synchronous, active high; clears the state machine and counters.
module radix_to_digit_string_unit
  import rtds_pkg::*;
#(
  parameter int MAX_DIGITS = 31
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  cmd_t    cmd;
  status_t status;

  // Controller: accept, divide until the quotient runs out, then pop digits.
  rtds_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .status    (status),
    .req_stall (req_stall),
    .cmd       (cmd)
  );

  // Datapath: divider pushes remainders; pops come back most significant first.
  rtds_dpath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .rsp_stall (rsp_stall),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

`ifndef SYNTHESIS
  // One item in flight: a request transfer closes the request side next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted while a conversion was under way");

  // A flagged result stands alone and ends its conversion.
  a_flag_is_last: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.no_digits || rsp.bad_radix)) |-> (rsp.last &&
      !(rsp.no_digits && rsp.bad_radix)))
    else $error("flagged result not marked last or doubly flagged");

  // A digit transfer carries a legal digit character.
  a_digit_char: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.no_digits && !rsp.bad_radix) |->
      ((rsp.digit_char >= 8'h30 && rsp.digit_char <= 8'h39) ||
       (rsp.digit_char >= 8'h41 && rsp.digit_char <= 8'h5A)))
    else $error("digit character out of range");
`endif

endmodule

FILE: src/rtds_ctrl.sv
// Controller state machine: sequences division, stack pops and result loads.
module rtds_ctrl
  import rtds_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  input  status_t status,
  output logic    req_stall,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = status.special ? ST_FLAG : ST_DIV;
        end
      end
      ST_FLAG: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (status.digit_end) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (status.out_free) begin
          state_next = status.cnt_zero ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    req_stall      = (state != ST_IDLE);
    cmd.start      = (state == ST_IDLE) && req_valid;
    cmd.div_step   = (state == ST_DIV);
    cmd.pop        = (state == ST_READ);
    cmd.load_digit = (state == ST_LOAD) && status.out_free;
    cmd.load_flag  = (state == ST_FLAG) && status.out_free;
  end

endmodule

FILE: src/rtds_dpath.sv
// Datapath: iterative divider, digit stack memory and output register.
module rtds_dpath
  import rtds_pkg::*;
#(
  parameter int MAX_DIGITS = 31
) (
  input  logic      clk,
  input  logic      rst,
  input  req_item_t req,
  input  cmd_t      cmd,
  input  logic      rsp_stall,
  output status_t   status,
  output logic      rsp_valid,
  output rsp_item_t rsp
);

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  logic [DIV_W-1:0]       dq;
  logic [RADIX_WIDTH-1:0] radix_r;
  logic [DIGIT_WIDTH-1:0] rem;
  logic [STEP_CNT_W-1:0]  step;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       count_dec;
  logic                   flag_bad;
  logic                   flag_zero;
  logic [DIGIT_WIDTH-1:0] rdata;
  logic [DIGIT_WIDTH-1:0] stack [MAX_DIGITS];

  logic [DIGIT_WIDTH:0]   div_r;
  logic [DIV_W-1:0]       div_d;
  logic                   last_step;
  logic                   bad_in;
  logic                   zero_in;

  assign bad_in    = (req.radix < RADIX_WIDTH'(RADIX_MIN)) ||
                     (req.radix > RADIX_WIDTH'(DIGIT_MAX + 1));
  assign zero_in   = (req.value == '0);
  assign last_step = (step == STEP_CNT_W'(STEPS - 1));
  assign count_dec = count - 1'b1;

  // Restoring division, STEP_BITS quotient bits per cycle, MSB first.
  always_comb begin
    div_r = {1'b0, rem};
    div_d = dq;
    for (int i = 0; i < STEP_BITS; i++) begin
      div_r = {div_r[DIGIT_WIDTH-1:0], div_d[DIV_W-1]};
      div_d = {div_d[DIV_W-2:0], 1'b0};
      if (div_r >= {1'b0, radix_r}) begin
        div_r    = div_r - {1'b0, radix_r};
        div_d[0] = 1'b1;
      end
    end
  end

  always_comb begin
    status.special   = bad_in || zero_in;
    status.digit_end = last_step &&
                       ((div_d == '0) || (count == CNT_W'(MAX_DIGITS - 1)));
    status.cnt_zero  = (count == '0);
    status.out_free  = !rsp_valid || !rsp_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step  <= '0;
      count <= '0;
    end else if (cmd.start) begin
      step  <= '0;
      count <= '0;
    end else if (cmd.div_step) begin
      if (last_step) begin
        step  <= '0;
        count <= count + 1'b1;
      end else begin
        step <= step + 1'b1;
      end
    end else if (cmd.pop) begin
      count <= count_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dq        <= DIV_W'(req.value);
      radix_r   <= req.radix;
      rem       <= '0;
      flag_bad  <= bad_in;
      flag_zero <= !bad_in && zero_in;
    end else if (cmd.div_step) begin
      dq  <= div_d;
      rem <= last_step ? '0 : div_r[DIGIT_WIDTH-1:0];
    end
  end

  // Digit stack: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.div_step && last_step) begin
      stack[count[IDX_W-1:0]] <= div_r[DIGIT_WIDTH-1:0];
    end
    if (cmd.pop) begin
      rdata <= stack[count_dec[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_digit || cmd.load_flag) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_digit) begin
      rsp.digit_char <= digit_to_ascii(rdata);
      rsp.last       <= status.cnt_zero;
      rsp.no_digits  <= 1'b0;
      rsp.bad_radix  <= 1'b0;
    end else if (cmd.load_flag) begin
      rsp.digit_char <= '0;
      rsp.last       <= 1'b1;
      rsp.no_digits  <= flag_zero;
      rsp.bad_radix  <= flag_bad;
    end
  end

endmodule
